// File: rtl/kvte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvte_pkg
// Shared types, codes and default sizes of the key/value table with expiry.
// ----------------------------------------------------------------------------
package kvte_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 64;
    localparam int VALUE_BITS_DEF    = 64;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int SECOND_W = 32;
    localparam int LIFE_W   = 24;
    localparam int LIVE_W   = 7;

    localparam logic [OP_W-1:0] OP_SET  = 3'd0;
    localparam logic [OP_W-1:0] OP_GET  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_TTL  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NIL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VALUE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMAIN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOEXP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_ACT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic              key_match;
        logic              exp_before_now;
        logic              exp_not_after_now;
        logic [LIFE_W-1:0] remaining;
    } eval_t;

endpackage

// File: rtl/kvte_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvte_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvte_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 162,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kvte_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvte_eval
// Shared compare unit: key match and expiry subtract against the current second.
// ----------------------------------------------------------------------------
module kvte_eval #(
    parameter int KEY_BITS = 64
) (
    input  logic [KEY_BITS-1:0]          entry_key,
    input  logic [KEY_BITS-1:0]          item_key,
    input  logic [kvte_pkg::SECOND_W-1:0] expiry,
    input  logic [kvte_pkg::SECOND_W-1:0] now,
    output kvte_pkg::eval_t              result
);

    logic [kvte_pkg::SECOND_W:0] diff;

    assign diff = {1'b0, expiry} - {1'b0, now};

    always_comb
    begin
        result.key_match         = (entry_key == item_key);
        result.exp_before_now    = diff[kvte_pkg::SECOND_W];
        result.exp_not_after_now = diff[kvte_pkg::SECOND_W] || (diff == '0);
        if (diff[kvte_pkg::SECOND_W-1:kvte_pkg::LIFE_W] != '0)
        begin
            result.remaining = '1;
        end
        else
        begin
            result.remaining = diff[kvte_pkg::LIFE_W-1:0];
        end
    end

endmodule

// File: rtl/key_value_table_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_with_expiry
// Fixed-capacity key/value table with per-entry expiry second.
//
// A command (set, get, delete, ttl query, tick) is taken at a rising edge
// where start is high and busy is low. Every command with a used opcode walks
// the whole table, one entry read per cycle from the entry memory, through one
// shared compare unit; S_ACT then updates the addressed entry as needed.
// The result is shown for exactly one cycle with done high; it is accepted
// at the edge ending that cycle and the receiver cannot stall it.
// A new command may be started in the done cycle; the table takes no new
// command while one is still running, busy being high until S_ACT ends.
// An unused opcode skips the walk and goes straight to S_ACT.
// After reset a clearing pass empties every entry of the table
// while busy stays high; the seconds counter and the expired count are zero.
// cleaned_count and live_entries give the state after the command.
// ----------------------------------------------------------------------------
module key_value_table_with_expiry #(
    parameter int TABLE_ENTRIES = kvte_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = kvte_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS    = kvte_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [kvte_pkg::OP_W-1:0]       opcode,
    input  logic [KEY_BITS-1:0]             item_key,
    input  logic [VALUE_BITS-1:0]           item_value,
    input  logic [kvte_pkg::LIFE_W-1:0]     lifetime_seconds,
    output logic                            done,
    output logic [kvte_pkg::STATUS_W-1:0]   status,
    output logic [VALUE_BITS-1:0]           found_value,
    output logic [kvte_pkg::LIFE_W-1:0]     remaining_seconds,
    output logic [kvte_pkg::SECOND_W-1:0]   cleaned_count,
    output logic [kvte_pkg::LIVE_W-1:0]     live_entries
);

    localparam int ADDR_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int EXT_W    = (CNT_W > kvte_pkg::LIVE_W) ? CNT_W : kvte_pkg::LIVE_W;
    localparam int KEY_LO   = VALUE_BITS;
    localparam int EXP_LO   = VALUE_BITS + KEY_BITS;
    localparam int HAS_BIT  = EXP_LO + kvte_pkg::SECOND_W;
    localparam int VLD_BIT  = HAS_BIT + 1;
    localparam int WORD_W   = VLD_BIT + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    kvte_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]              addr_reg, addr_next;
    logic                           issue_reg, issue_next;
    logic                           pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]              pipe_addr_reg, pipe_addr_next;
    logic [kvte_pkg::SECOND_W-1:0]  cur_reg, cur_next;
    logic [kvte_pkg::SECOND_W-1:0]  expired_reg, expired_next;
    logic [CNT_W-1:0]               live_reg, live_next;
    logic                           hit_reg, hit_next;
    logic                           free_reg, free_next;
    logic                           done_reg, done_next;

    logic [kvte_pkg::OP_W-1:0]      op_reg, op_next;
    logic [KEY_BITS-1:0]            key_reg, key_next;
    logic [VALUE_BITS-1:0]          value_reg, value_next;
    logic [kvte_pkg::LIFE_W-1:0]    life_reg, life_next;
    logic [ADDR_W-1:0]              hit_addr_reg, hit_addr_next;
    logic [VALUE_BITS-1:0]          hit_value_reg, hit_value_next;
    logic                           hit_has_reg, hit_has_next;
    logic [kvte_pkg::SECOND_W-1:0]  hit_exp_reg, hit_exp_next;
    logic [ADDR_W-1:0]              free_addr_reg, free_addr_next;
    logic [kvte_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [VALUE_BITS-1:0]          fval_reg, fval_next;
    logic [kvte_pkg::LIFE_W-1:0]    rem_reg, rem_next;

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [WORD_W-1:0]              wr_data;
    logic                           rd_en;
    logic [WORD_W-1:0]              rd_data;

    logic                           rd_valid;
    logic                           rd_has;
    logic [kvte_pkg::SECOND_W-1:0]  rd_exp;
    logic [KEY_BITS-1:0]            rd_key;
    logic [VALUE_BITS-1:0]          rd_value;
    logic [kvte_pkg::SECOND_W-1:0]  eval_exp;
    kvte_pkg::eval_t                ev;

    logic                           accept;
    logic                           exp_inc;
    logic                           live_inc;
    logic                           live_dec;
    logic [kvte_pkg::SECOND_W:0]    exp_sum;
    logic [kvte_pkg::SECOND_W-1:0]  new_exp;
    logic                           new_has;
    logic [EXT_W-1:0]               live_ext;

    assign rd_valid = rd_data[VLD_BIT];
    assign rd_has   = rd_data[HAS_BIT];
    assign rd_exp   = rd_data[HAS_BIT-1:EXP_LO];
    assign rd_key   = rd_data[EXP_LO-1:KEY_LO];
    assign rd_value = rd_data[KEY_LO-1:0];

    assign accept   = start && (state_reg == kvte_pkg::S_IDLE);
    assign eval_exp = (state_reg == kvte_pkg::S_ACT) ? hit_exp_reg : rd_exp;
    assign rd_en    = (state_reg == kvte_pkg::S_SCAN) && issue_reg;

    assign exp_sum  = {1'b0, cur_reg} + (kvte_pkg::SECOND_W + 1)'(life_reg);
    assign new_has  = (life_reg != '0);
    assign new_exp  = !new_has ? '0 :
                      exp_sum[kvte_pkg::SECOND_W] ? '1 : exp_sum[kvte_pkg::SECOND_W-1:0];

    kvte_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    kvte_eval #(
        .KEY_BITS (KEY_BITS)
    ) u_eval (
        .entry_key (rd_key),
        .item_key  (key_reg),
        .expiry    (eval_exp),
        .now       (cur_reg),
        .result    (ev)
    );

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        pipe_vld_next  = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        cur_next       = cur_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        done_next      = 1'b0;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        life_next      = life_reg;
        hit_addr_next  = hit_addr_reg;
        hit_value_next = hit_value_reg;
        hit_has_next   = hit_has_reg;
        hit_exp_next   = hit_exp_reg;
        free_addr_next = free_addr_reg;
        status_next    = status_reg;
        fval_next      = fval_reg;
        rem_next       = rem_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '0;
        exp_inc        = 1'b0;
        live_inc       = 1'b0;
        live_dec       = 1'b0;

        unique case (state_reg)
            kvte_pkg::S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = kvte_pkg::S_IDLE;
                end
            end
            kvte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    key_next   = item_key;
                    value_next = item_value;
                    life_next  = lifetime_seconds;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    addr_next  = '0;
                    issue_next = 1'b1;
                    if (opcode == kvte_pkg::OP_TICK && cur_reg != '1)
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                    if (opcode > kvte_pkg::OP_TICK)
                    begin
                        state_next = kvte_pkg::S_ACT;
                    end
                    else
                    begin
                        state_next = kvte_pkg::S_SCAN;
                    end
                end
            end
            kvte_pkg::S_SCAN:
            begin
                if (issue_reg)
                begin
                    addr_next  = addr_reg + 1'b1;
                    issue_next = (addr_reg != LAST_ADDR);
                end
                pipe_vld_next  = issue_reg;
                pipe_addr_next = addr_reg;
                if (pipe_vld_reg)
                begin
                    if (rd_valid && ev.key_match)
                    begin
                        hit_next       = 1'b1;
                        hit_addr_next  = pipe_addr_reg;
                        hit_value_next = rd_value;
                        hit_has_next   = rd_has;
                        hit_exp_next   = rd_exp;
                    end
                    if (!rd_valid && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_addr_next = pipe_addr_reg;
                    end
                    // tick sweep: drop entries that expired before the new second
                    if (op_reg == kvte_pkg::OP_TICK && rd_valid && rd_has
                        && ev.exp_before_now)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = pipe_addr_reg;
                        exp_inc  = 1'b1;
                        live_dec = 1'b1;
                    end
                    if (pipe_addr_reg == LAST_ADDR)
                    begin
                        state_next = kvte_pkg::S_ACT;
                    end
                end
            end
            kvte_pkg::S_ACT:
            begin
                state_next  = kvte_pkg::S_IDLE;
                done_next   = 1'b1;
                fval_next   = '0;
                rem_next    = '0;
                status_next = kvte_pkg::ST_NIL;
                wr_addr     = hit_addr_reg;
                unique case (op_reg)
                    kvte_pkg::OP_SET:
                    begin
                        wr_data = {1'b1, new_has, new_exp, key_reg, value_reg};
                        if (hit_reg)
                        begin
                            wr_en       = 1'b1;
                            status_next = kvte_pkg::ST_OK;
                        end
                        else if (free_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = free_addr_reg;
                            live_inc    = 1'b1;
                            status_next = kvte_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = kvte_pkg::ST_FULL;
                        end
                    end
                    kvte_pkg::OP_GET:
                    begin
                        if (hit_reg)
                        begin
                            if (hit_has_reg && ev.exp_before_now)
                            begin
                                wr_en    = 1'b1;
                                exp_inc  = 1'b1;
                                live_dec = 1'b1;
                            end
                            else
                            begin
                                status_next = kvte_pkg::ST_VALUE;
                                fval_next   = hit_value_reg;
                            end
                        end
                    end
                    kvte_pkg::OP_DEL:
                    begin
                        if (hit_reg)
                        begin
                            wr_en       = 1'b1;
                            live_dec    = 1'b1;
                            status_next = kvte_pkg::ST_OK;
                        end
                    end
                    kvte_pkg::OP_TTL:
                    begin
                        if (hit_reg)
                        begin
                            if (!hit_has_reg)
                            begin
                                status_next = kvte_pkg::ST_NOEXP;
                            end
                            else if (ev.exp_not_after_now)
                            begin
                                wr_en    = 1'b1;
                                exp_inc  = 1'b1;
                                live_dec = 1'b1;
                            end
                            else
                            begin
                                status_next = kvte_pkg::ST_REMAIN;
                                rem_next    = ev.remaining;
                            end
                        end
                    end
                    kvte_pkg::OP_TICK:
                    begin
                        status_next = kvte_pkg::ST_OK;
                    end
                    default:
                    begin
                        status_next = kvte_pkg::ST_NIL;
                    end
                endcase
            end
            default:
            begin
                state_next = kvte_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        expired_next = expired_reg;
        if (exp_inc && expired_reg != '1)
        begin
            expired_next = expired_reg + 1'b1;
        end
        live_next = live_reg;
        if (live_inc)
        begin
            live_next = live_reg + 1'b1;
        end
        else if (live_dec)
        begin
            live_next = live_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kvte_pkg::S_CLEAR;
            addr_reg     <= '0;
            issue_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
            cur_reg      <= '0;
            expired_reg  <= '0;
            live_reg     <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            issue_reg    <= issue_next;
            pipe_vld_reg <= pipe_vld_next;
            cur_reg      <= cur_next;
            expired_reg  <= expired_next;
            live_reg     <= live_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= pipe_addr_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        life_reg      <= life_next;
        hit_addr_reg  <= hit_addr_next;
        hit_value_reg <= hit_value_next;
        hit_has_reg   <= hit_has_next;
        hit_exp_reg   <= hit_exp_next;
        free_addr_reg <= free_addr_next;
        status_reg    <= status_next;
        fval_reg      <= fval_next;
        rem_reg       <= rem_next;
    end

    assign live_ext = EXT_W'(live_reg);

    assign busy              = (state_reg != kvte_pkg::S_IDLE);
    assign done              = done_reg;
    assign status            = status_reg;
    assign found_value       = fval_reg;
    assign remaining_seconds = rem_reg;
    assign cleaned_count     = expired_reg;
    assign live_entries      = (live_ext > EXT_W'(127)) ? kvte_pkg::LIVE_W'(127)
                                                         : live_ext[kvte_pkg::LIVE_W-1:0];

endmodule
